// ----- src/spe_pkg.sv -----
// Package for the sparse polynomial evaluator/differentiator.
// Mode and status codes, fixed-point helpers. No dependencies.
package spe_pkg;
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_EVAL   = 2'd2;
  localparam logic [1:0] MODE_DERIVE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_VAR  = 2'd2;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  // saturate a 64-bit signed value to 32 bits
  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[31:0];
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.val = S32_MAX;
      r.ovf = 1'b1;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r.val = S32_MIN;
      r.ovf = 1'b1;
    end
    return r;
  endfunction
endpackage

// ----- src/spe_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module spe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/sparse_poly_eval_derive_top.sv -----
// Top level of the sparse polynomial evaluator/differentiator.
// Uses spe_pkg and spe_ram (coefficient and power tables).
//
//  channel | ports                           | direction
//  cfg     | cfg_valid/ready, cfg_data       | in  (num_variables)
//  in      | in_valid/ready, mode..derive_var| in  (request)
//  out     | out_valid/ready, value..status  | out (result)
//
// Clear and add: the result is registered through S_DONE. Evaluate: per term a table
// read and accumulate (S_ERD, S_EWAIT, S_ECOEF), an S_EPOW/S_EACC pair per power step
// and an S_EPOW/S_EPROD pair per variable, all through the single shared 32x32 multiplier.
// Derive: per term S_DRD, S_DWAIT and S_DWR scale and compact through the memory ports.
// Reset clears control only; the tables need no clearing. A new request is taken
// once the block is idle and the result register is free.
module sparse_poly_eval_derive_top
  import spe_pkg::*;
#(
  parameter int MAX_TERMS = 16,
  parameter int MAX_VARS  = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_coefficient,
  input  logic [3:0]         in_power_0,
  input  logic [3:0]         in_power_1,
  input  logic [3:0]         in_power_2,
  input  logic [3:0]         in_power_3,
  input  logic signed [31:0] in_coord_0,
  input  logic signed [31:0] in_coord_1,
  input  logic signed [31:0] in_coord_2,
  input  logic signed [31:0] in_coord_3,
  input  logic [1:0]         in_derive_var,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [4:0]         out_term_count,
  output logic               out_overflow,
  output logic [1:0]         out_status
);
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERD   = 4'd1;  // eval: issue read
  localparam logic [3:0] S_EWAIT = 4'd2;  // eval: data arrives
  localparam logic [3:0] S_EPOW  = 4'd3;  // pw *= x
  localparam logic [3:0] S_EPROD = 4'd4;  // prod *= pw
  localparam logic [3:0] S_ECOEF = 4'd5;  // c * prod, accumulate
  localparam logic [3:0] S_DRD   = 4'd6;
  localparam logic [3:0] S_DWAIT = 4'd7;
  localparam logic [3:0] S_DWR   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_EACC  = 4'd10;

  logic [3:0]         state_r, state_nxt;
  logic [2:0]         nvar_r;
  logic [CW-1:0]      used_r, used_nxt;
  logic [CW-1:0]      t_r, t_nxt;
  logic [CW-1:0]      w_r, w_nxt;
  logic [VW-1:0]      v_r, v_nxt;
  logic [3:0]         k_r, k_nxt;
  logic [1:0]         dv_r;
  logic signed [31:0] x_r [4];
  logic signed [31:0] pw_r, pw_nxt, prod_r, prod_nxt, acc_r, acc_nxt;
  logic signed [31:0] coef_r, coef_nxt;
  logic [15:0]        pwt_r, pwt_nxt;
  logic signed [63:0] mul_r;
  logic               ovf_r, ovf_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic               ov_r, ov_nxt;
  logic signed [31:0] oval_r, oval_nxt;
  logic [4:0]         ocnt_r, ocnt_nxt;
  logic               oovf_r, oovf_nxt;
  logic [1:0]         ost_r, ost_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        c_wdata, c_rdata;
  logic [15:0]        p_wdata, p_rdata;

  logic [2:0]         nv_eff;
  logic signed [31:0] ma, mb;
  logic signed [63:0] mq;
  sat_t               s_mul, s_sum, s_scl;
  logic [3:0]         p_cur;

  spe_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_coef (
    .clk, .we, .waddr, .wdata(c_wdata), .raddr, .rdata(c_rdata));
  spe_ram #(.WIDTH(16), .DEPTH(MAX_TERMS)) u_pow (
    .clk, .we, .waddr, .wdata(p_wdata), .raddr, .rdata(p_rdata));

  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_value = oval_r;
  assign out_term_count = ocnt_r;
  assign out_overflow = oovf_r;
  assign out_status = ost_r;

  always_comb begin
    nv_eff = (nvar_r == 3'd0) ? 3'd1 : nvar_r;
    if (nv_eff > 3'(MAX_VARS)) nv_eff = 3'(MAX_VARS);
  end

  // floor(mul/65536) is an arithmetic shift
  always_comb begin
    mq = mul_r >>> 16;
    s_mul = sat64(mq);
    s_sum = sat64(64'(acc_r) + 64'(s_mul.val));
    s_scl = sat64(mul_r);
  end

  always_comb begin
    p_cur = pwt_r[{v_r, 2'b00} +: 4];
  end

  always_ff @(posedge clk) begin
    mul_r <= 64'(ma) * 64'(mb);
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    t_nxt = t_r;
    w_nxt = w_r;
    v_nxt = v_r;
    k_nxt = k_r;
    pw_nxt = pw_r;
    prod_nxt = prod_r;
    acc_nxt = acc_r;
    coef_nxt = coef_r;
    pwt_nxt = pwt_r;
    ovf_nxt = ovf_r;
    stat_nxt = stat_r;
    ov_nxt = ov_r;
    oval_nxt = oval_r;
    ocnt_nxt = ocnt_r;
    oovf_nxt = oovf_r;
    ost_nxt = ost_r;
    we = 1'b0;
    waddr = w_r[AW-1:0];
    c_wdata = coef_r;
    p_wdata = pwt_r;
    raddr = t_r[AW-1:0];
    ma = pw_r;
    mb = x_r[v_r];
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          t_nxt = '0;
          w_nxt = '0;
          acc_nxt = '0;
          ovf_nxt = 1'b0;
          stat_nxt = ST_OK;
          state_nxt = S_DONE;
          case (in_mode)
            MODE_CLEAR: used_nxt = '0;
            MODE_ADD: begin
              if (used_r >= CW'(MAX_TERMS)) begin
                stat_nxt = ST_FULL;
              end else begin
                we = 1'b1;
                waddr = used_r[AW-1:0];
                c_wdata = in_coefficient;
                p_wdata = {in_power_3, in_power_2, in_power_1, in_power_0};
                used_nxt = used_r + 1'b1;
              end
            end
            MODE_EVAL: state_nxt = S_ERD;
            default: begin
              if ({1'b0, in_derive_var} >= nv_eff) stat_nxt = ST_BAD_VAR;
              else state_nxt = S_DRD;
            end
          endcase
        end
      end
      S_ERD: begin
        if (t_r == used_r) state_nxt = S_DONE;
        else state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        coef_nxt = c_rdata;
        pwt_nxt = p_rdata;
        v_nxt = '0;
        k_nxt = '0;
        pw_nxt = Q_ONE;
        prod_nxt = Q_ONE;
        state_nxt = S_EPOW;
      end
      S_EPOW: begin
        // multiplier fed pw*x this cycle when k < p
        if (k_r < p_cur) begin
          state_nxt = S_EACC;
        end else begin
          ma = prod_r;
          mb = pw_r;
          state_nxt = S_EPROD;
        end
      end
      S_EACC: begin
        pw_nxt = s_mul.val;
        ovf_nxt = ovf_r | s_mul.ovf;
        k_nxt = k_r + 1'b1;
        state_nxt = S_EPOW;
      end
      S_EPROD: begin
        prod_nxt = s_mul.val;
        ovf_nxt = ovf_r | s_mul.ovf;
        pw_nxt = Q_ONE;
        k_nxt = '0;
        if (3'(v_r) + 3'd1 >= nv_eff) begin
          ma = coef_r;
          mb = s_mul.val;
          state_nxt = S_ECOEF;
        end else begin
          v_nxt = v_r + 1'b1;
          state_nxt = S_EPOW;
        end
      end
      S_ECOEF: begin
        acc_nxt = s_sum.val;
        ovf_nxt = ovf_r | s_mul.ovf | s_sum.ovf;
        t_nxt = t_r + 1'b1;
        state_nxt = S_ERD;
      end
      S_DRD: begin
        if (t_r == used_r) begin
          used_nxt = w_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        pwt_nxt = p_rdata;
        coef_nxt = c_rdata;
        ma = c_rdata;
        mb = 32'(p_rdata[{dv_r, 2'b00} +: 4]);
        state_nxt = S_DWR;
      end
      S_DWR: begin
        // write index w <= t, so reads ahead are never clobbered
        t_nxt = t_r + 1'b1;
        state_nxt = S_DRD;
        if (pwt_r[{dv_r, 2'b00} +: 4] != 4'd0) begin
          ovf_nxt = ovf_r | s_scl.ovf;
          if (s_scl.val != 32'sd0) begin
            we = 1'b1;
            c_wdata = s_scl.val;
            p_wdata = pwt_r - (16'd1 << {dv_r, 2'b00});
            w_nxt = w_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          oval_nxt = acc_r;
          ocnt_nxt = 5'(used_r);
          oovf_nxt = ovf_r;
          ost_nxt = stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nvar_r <= 3'd1;
      used_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) nvar_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
    w_r <= w_nxt;
    v_r <= v_nxt;
    k_r <= k_nxt;
    pw_r <= pw_nxt;
    prod_r <= prod_nxt;
    acc_r <= acc_nxt;
    coef_r <= coef_nxt;
    pwt_r <= pwt_nxt;
    ovf_r <= ovf_nxt;
    stat_r <= stat_nxt;
    oval_r <= oval_nxt;
    ocnt_r <= ocnt_nxt;
    oovf_r <= oovf_nxt;
    ost_r <= ost_nxt;
    if (in_valid && in_ready) begin
      dv_r <= in_derive_var;
      x_r[0] <= in_coord_0;
      x_r[1] <= in_coord_1;
      x_r[2] <= in_coord_2;
      x_r[3] <= in_coord_3;
    end
  end

  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_TERMS)) else $error("term count above table size");
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWR) |-> (w_r <= t_r)) else $error("compaction overran read index");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("request taken while busy");
endmodule

// ----- bench/tb_sparse_poly_eval_derive_top.sv -----
`timescale 1ns / 100ps
// Testbench for sparse_poly_eval_derive_top: random and directed requests
// checked against a term-table predictor in a scoreboard class. Uses spe_pkg.
module tb_sparse_poly_eval_derive_top;
  import spe_pkg::*;

  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] coef;
    logic [3:0]         pw[4];
    logic signed [31:0] x[4];
    logic [1:0]         dv;
  } poly_req_t;

  typedef struct {
    logic signed [31:0] value;
    logic [4:0]         count;
    logic               ovf;
    logic [1:0]         status;
  } poly_res_t;

  class poly_scoreboard;
    logic signed [31:0] coeff[16];
    logic [15:0]        powers[16];
    int unsigned        used;
    logic [2:0]         nvars;
    bit                 ovf;
    poly_res_t          pending[$];
    int                 errors;

    function new();
      used = 0;
      nvars = 1;
      errors = 0;
    endfunction

    function logic signed [31:0] sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
        ovf = 1;
        return S32_MAX;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1;
        return S32_MIN;
      end
      return v[31:0];
    endfunction

    function logic signed [31:0] qmul(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [63:0] p;
      p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
      return sat(p >>> 16);
    endfunction

    function int unsigned vars_used();
      if (nvars == 0) return 1;
      if (nvars > 4) return 4;
      return nvars;
    endfunction

    function void note_request(input poly_req_t r);
      poly_res_t e;
      int unsigned nv, w;
      logic signed [31:0] prod, pw;
      logic [3:0] p;
      nv = vars_used();
      ovf = 0;
      e.value = 0;
      e.status = ST_OK;
      case (r.mode)
        MODE_CLEAR: used = 0;
        MODE_ADD: begin
          if (used >= 16) e.status = ST_FULL;
          else begin
            coeff[used] = r.coef;
            powers[used] = {r.pw[3], r.pw[2], r.pw[1], r.pw[0]};
            used++;
          end
        end
        MODE_EVAL: begin
          for (int t = 0; t < used; t++) begin
            prod = Q_ONE;
            for (int v = 0; v < nv; v++) begin
              pw = Q_ONE;
              p = powers[t][4*v +: 4];
              for (int k = 0; k < p; k++) pw = qmul(pw, r.x[v]);
              prod = qmul(prod, pw);
            end
            e.value = sat(64'(e.value) + 64'(qmul(coeff[t], prod)));
          end
        end
        default: begin
          if (r.dv >= nv) e.status = ST_BAD_VAR;
          else begin
            for (int t = 0; t < used; t++) begin
              p = powers[t][4*r.dv +: 4];
              if (p == 0) coeff[t] = 0;
              else begin
                coeff[t] = sat(64'(coeff[t]) * 64'(p));
                powers[t] = powers[t] - (16'd1 << (4 * r.dv));
              end
            end
            w = 0;
            for (int t = 0; t < used; t++) begin
              if (coeff[t] != 0) begin
                coeff[w] = coeff[t];
                powers[w] = powers[t];
                w++;
              end
            end
            used = w;
          end
        end
      endcase
      e.count = used[4:0];
      e.ovf = ovf;
      pending.insert(pending.size(), e);
    endfunction

    task report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input poly_res_t got);
      poly_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.value !== e.value)
        report_mismatch($sformatf("value %h, want %h", got.value, e.value));
      if (got.count !== e.count)
        report_mismatch($sformatf("term_count %0d, want %0d", got.count, e.count));
      if (got.ovf !== e.ovf)
        report_mismatch($sformatf("overflow %b, want %b", got.ovf, e.ovf));
      if (got.status !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, e.status));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_mode;
  logic signed [31:0] in_coefficient;
  logic [3:0]         in_power_0, in_power_1, in_power_2, in_power_3;
  logic signed [31:0] in_coord_0, in_coord_1, in_coord_2, in_coord_3;
  logic [1:0]         in_derive_var;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_value;
  logic [4:0]         out_term_count;
  logic               out_overflow;
  logic [1:0]         out_status;

  poly_scoreboard sb;
  int send_idle;
  int recv_stall;
  int hold_cycles;

  sparse_poly_eval_derive_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_coefficient(in_coefficient),
    .in_power_0(in_power_0), .in_power_1(in_power_1),
    .in_power_2(in_power_2), .in_power_3(in_power_3),
    .in_coord_0(in_coord_0), .in_coord_1(in_coord_1),
    .in_coord_2(in_coord_2), .in_coord_3(in_coord_3),
    .in_derive_var(in_derive_var),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_term_count(out_term_count), .out_overflow(out_overflow),
    .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver ready, with long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    poly_res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.value = out_value;
      got.count = out_term_count;
      got.ovf = out_overflow;
      got.status = out_status;
      sb.check_result(got);
    end
  end

  // called and returns at a falling edge
  task automatic send_request(input poly_req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_mode <= r.mode;
    in_coefficient <= r.coef;
    in_power_0 <= r.pw[0];
    in_power_1 <= r.pw[1];
    in_power_2 <= r.pw[2];
    in_power_3 <= r.pw[3];
    in_coord_0 <= r.x[0];
    in_coord_1 <= r.x[1];
    in_coord_2 <= r.x[2];
    in_coord_3 <= r.x[3];
    in_derive_var <= r.dv;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_nvars(input logic [2:0] n);
    cfg_data <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.nvars = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic poly_req_t make_req(input logic [1:0] mode, input logic signed [31:0] c,
                                         input logic [3:0] p, input logic signed [31:0] xv,
                                         input logic [1:0] dv);
    poly_req_t r;
    r.mode = mode;
    r.coef = c;
    r.dv = dv;
    for (int v = 0; v < 4; v++) begin
      r.pw[v] = p;
      r.x[v] = xv;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_q();
    int unsigned s;
    s = $urandom_range(99);
    if (s < 60) return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
    if (s < 85) return $urandom;
    if (s < 90) return S32_MAX;
    if (s < 95) return S32_MIN;
    return Q_ONE;
  endfunction

  function automatic poly_req_t rand_req();
    poly_req_t r;
    int unsigned s;
    s = $urandom_range(99);
    r.mode = (s < 8) ? MODE_CLEAR : (s < 45) ? MODE_ADD : (s < 75) ? MODE_EVAL : MODE_DERIVE;
    r.coef = rand_q();
    r.dv = 2'($urandom_range(3));
    for (int v = 0; v < 4; v++) begin
      r.pw[v] = ($urandom_range(99) < 15) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      r.x[v] = rand_q();
    end
    return r;
  endfunction

  task automatic run_phase(input logic [2:0] n, input int idle, input int stall, input int count);
    drain();
    write_nvars(n);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < count; i++) send_request(rand_req());
  endtask

  initial begin
    sb = new();
    send_idle = 0;
    recv_stall = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = MODE_CLEAR;
    in_coefficient = '0;
    {in_power_0, in_power_1, in_power_2, in_power_3} = '0;
    {in_coord_0, in_coord_1, in_coord_2, in_coord_3} = '0;
    in_derive_var = '0;
    out_ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_nvars(3'd4);
    send_request(make_req(MODE_CLEAR, 0, 0, 0, 0));
    send_request(make_req(MODE_EVAL, 0, 0, Q_ONE, 0));
    send_request(make_req(MODE_ADD, S32_MAX, 4'd15, 0, 0));
    send_request(make_req(MODE_ADD, S32_MIN, 4'd0, 0, 0));
    send_request(make_req(MODE_ADD, 0, 4'd1, 0, 0));
    send_request(make_req(MODE_EVAL, 0, 0, S32_MAX, 0));
    send_request(make_req(MODE_EVAL, 0, 0, S32_MIN, 0));
    send_request(make_req(MODE_EVAL, 0, 0, 0, 0));
    send_request(make_req(MODE_DERIVE, 0, 0, 0, 2'd0));
    send_request(make_req(MODE_DERIVE, 0, 0, 0, 2'd3));
    send_request(make_req(MODE_EVAL, 0, 0, 32'sh0001_8000, 0));
    for (int i = 0; i < 16; i++)
      send_request(make_req(MODE_ADD, -32'sh0000_4000 * (i + 1), 4'd2, 0, 0));
    send_request(make_req(MODE_EVAL, 0, 0, -32'sh0002_0000, 0));

    run_phase(3'd4, 0, 0, 110);
    run_phase(3'd2, 81, 0, 110);
    run_phase(3'd3, 0, 81, 110);
    run_phase(3'd0, 31, 31, 110);
    run_phase(3'd7, 0, 0, 10);
    in_valid <= 1'b0;
    @(posedge clk);
    hold_cycles = 400;
    @(negedge clk);
    for (int i = 0; i < 40; i++)
      send_request(make_req(($urandom_range(1) != 0) ? MODE_ADD : MODE_CLEAR,
                            rand_q(), 4'($urandom_range(15)), 0, 0));
    run_phase(3'd1, 31, 31, 100);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- sparse_poly_eval_derive_top.f -----
src/spe_pkg.sv
src/spe_ram.sv
src/sparse_poly_eval_derive_top.sv
bench/tb_sparse_poly_eval_derive_top.sv
